// ===== design/apvmap_pkg.sv =====
package apvmap_pkg;

  // Fixed geometry of the readout chip
  localparam int unsigned ChannelsPerChip = 128;
  localparam int unsigned ChanW           = 7;
  localparam int unsigned StripW          = 13;
  localparam int unsigned SlotW           = 5;
  localparam int unsigned CountW          = 6;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] CFG_INTERLEAVED = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PLANE_IS_X  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHIP_SLOT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REVERSED    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CHIP_COUNT  = 3'd4;

  // Reset value of the chip count
  localparam logic [CountW-1:0] ChipCountRst = 6'd1;

  // Configuration as seen by the mapping logic
  typedef struct packed {
    logic              interleaved_layout;
    logic              plane_is_x;
    logic [SlotW-1:0]  chip_slot;
    logic              chip_reversed;
    logic [CountW-1:0] chips_on_plane;
  } cfg_t;

endpackage

// ===== design/apvmap_cfg.sv =====
module apvmap_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [apvmap_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [apvmap_pkg::CfgDataW-1:0] cfg_wdata,
  output apvmap_pkg::cfg_t                cfg
);
  import apvmap_pkg::*;

  cfg_t cfg_r;

  // Register file, writes to unknown indices are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interleaved_layout <= 1'b0;
      cfg_r.plane_is_x         <= 1'b0;
      cfg_r.chip_slot          <= '0;
      cfg_r.chip_reversed      <= 1'b0;
      cfg_r.chips_on_plane     <= ChipCountRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_INTERLEAVED: cfg_r.interleaved_layout <= cfg_wdata[0];
        CFG_PLANE_IS_X:  cfg_r.plane_is_x         <= cfg_wdata[0];
        CFG_CHIP_SLOT:   cfg_r.chip_slot          <= cfg_wdata[SlotW-1:0];
        CFG_REVERSED:    cfg_r.chip_reversed      <= cfg_wdata[0];
        CFG_CHIP_COUNT:  cfg_r.chips_on_plane     <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/apvmap_map.sv =====
module apvmap_map (
  input  apvmap_pkg::cfg_t                     cfg,
  input  logic [apvmap_pkg::ChanW-1:0]         channel,
  output logic signed [apvmap_pkg::StripW-1:0] strip_number,
  output logic                                 strip_valid
);
  import apvmap_pkg::*;

  logic              x_layout;
  logic              slot11;
  logic [9:0]        reord_sum;
  logic [ChanW-1:0]  v_reord;
  logic [ChanW-1:0]  v_perm;
  logic [ChanW-1:0]  v_final;
  logic [CountW-1:0] divisor;
  logic [CountW-1:0] dividend;
  logic [CountW-1:0] rem1;
  logic [CountW-1:0] rem2;
  logic              div_pos;
  logic [11:0]       base;
  logic [StripW-1:0] shift;
  logic [StripW-1:0] strip;

  assign x_layout = cfg.interleaved_layout & cfg.plane_is_x;
  assign slot11   = x_layout && (cfg.chip_slot == 5'd11);

  // Chip channel reorder: 32*(ch%4) + 8*(ch/4) - 31*(ch/16), always 0..127
  assign reord_sum = {3'b0, channel[1:0], 5'b0} + {2'b0, channel[6:2], 3'b0}
                   - (10'(channel[6:4]) * 10'd31);
  assign v_reord   = reord_sum[ChanW-1:0];

  // Parity-based interleave; odd values fold down from the top or bottom half
  always_comb begin
    v_perm = v_reord;
    if (cfg.interleaved_layout) begin
      if (slot11) begin
        if (!v_reord[0])         v_perm = 7'(v_reord[6:1]) + 7'd48;
        else if (v_reord < 7'd96) v_perm = 7'((7'd95 - v_reord) >> 1);
        else                      v_perm = 7'd127 - 7'((v_reord - 7'd97) >> 1);
      end else begin
        if (!v_reord[0])         v_perm = 7'(v_reord[6:1]) + 7'd32;
        else if (v_reord < 7'd64) v_perm = 7'((7'd63 - v_reord) >> 1);
        else                      v_perm = 7'd127 - 7'((v_reord - 7'd65) >> 1);
      end
    end
  end

  // Mirror; on slot 11 of an X plane the double mirror cancels out
  assign v_final = (cfg.chip_reversed && !slot11) ? ~v_perm : v_perm;

  // Divisor and validity
  assign divisor = x_layout ? cfg.chips_on_plane - 6'd1 : cfg.chips_on_plane;
  assign div_pos = x_layout ? (cfg.chips_on_plane >= 6'd2)
                            : (cfg.chips_on_plane != 6'd0);
  assign strip_valid = ({1'b0, cfg.chip_slot} <= cfg.chips_on_plane) && div_pos;

  // Remainder: for a valid strip the dividend never exceeds divisor+1, two conditional subtracts suffice
  assign dividend = slot11 ? 6'd10 : {1'b0, cfg.chip_slot};
  assign rem1     = (dividend >= divisor) ? dividend - divisor : dividend;
  assign rem2     = (rem1 >= divisor) ? rem1 - divisor : rem1;

  // 128*rem + v, then the X-plane shift
  assign base  = {rem2[SlotW-1:0], v_final};
  assign shift = slot11 ? 13'd32 : (x_layout ? 13'd16 : 13'd0);
  assign strip = {1'b0, base} - shift;

  assign strip_number = strip_valid ? signed'(strip) : '0;

endmodule

// ===== design/apv_channel_to_strip_mapper_core.sv =====
// Channel to strip mapper: one result per channel, in order.
// The input register feeds the mapping logic, whose result the result register captures.
// Throughput: one channel per cycle while out_stall is low; the mapping is a single pass.
// Reset (rst_n, synchronous, active low) empties both stages and loads the
// configuration defaults (chip count 1, all other registers 0).
module apv_channel_to_strip_mapper_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [apvmap_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [apvmap_pkg::CfgDataW-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [apvmap_pkg::ChanW-1:0]         in_channel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [apvmap_pkg::StripW-1:0] out_strip_number,
  output logic                                 out_strip_valid
);
  import apvmap_pkg::*;

  cfg_t                     cfg;
  logic                     s1_valid_r;
  logic [ChanW-1:0]         s1_chan_r;
  logic                     s2_valid_r;
  logic signed [StripW-1:0] s2_strip_r;
  logic                     s2_sv_r;
  logic signed [StripW-1:0] map_strip;
  logic                     map_sv;
  logic                     s2_adv;
  logic                     s1_adv;

  apvmap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  apvmap_map u_map (
    .cfg          (cfg),
    .channel      (s1_chan_r),
    .strip_number (map_strip),
    .strip_valid  (map_sv)
  );

  // Handshake: result register frees when empty or taken
  assign s2_adv   = !s2_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_chan_r <= in_channel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_strip_r <= map_strip;
      s2_sv_r    <= map_sv;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_strip_number = s2_strip_r;
  assign out_strip_valid  = s2_sv_r;

`ifndef SYNTHESIS
  // An invalid mapping always carries strip zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_strip_valid |-> out_strip_number == '0)
    else $error("invalid strip with non-zero number");

  // A valid strip never lies below the largest X-plane shift
  a_strip_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_strip_valid |-> out_strip_number >= -13'sd32)
    else $error("strip number below lower bound");

  // An item leaving the input register lands in the result register
  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_adv |=> s2_valid_r)
    else $error("item lost between stages");

  // A stalled input item is kept
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_adv |=> s1_valid_r && $stable(s1_chan_r))
    else $error("stalled input item lost");
`endif

endmodule
